// File: hw/rtl/ptg_pkg.sv
// Package for the preset tone generator: transaction structs, codes,
// phase increments, amplitudes, quarter-wave sine table and Q1.15 multiply.
// No dependencies.
package ptg_pkg;

	localparam longint unsigned SAMPLE_RATE = 64'd48000;
	localparam int PHASE_W   = 32;
	localparam int SINE_AW   = 10;
	localparam int QTR_AW    = SINE_AW - 2;
	localparam int QTR_DEPTH = 1 << QTR_AW;
	localparam int U_SHIFT   = 30 - QTR_AW;
	localparam int NUM_TONES = 6;
	localparam int SPF_W     = 13;
	localparam int SIF_W     = 12;
	localparam int FPT_W     = 8;
	localparam logic [SPF_W-1:0] SPF_MAX = SPF_W'(4096);
	localparam logic [SPF_W-1:0] SPF_RST = SPF_W'(960);
	localparam logic [FPT_W-1:0] FPT_RST = FPT_W'(48);

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_PLAY = 2'd1,
		ACT_STOP = 2'd2,
		ACT_NOP  = 2'd3
	} action_t;

	typedef enum logic {
		CFG_SPF = 1'b0,
		CFG_FPT = 1'b1
	} cfg_idx_t;

	localparam logic [2:0] TONE_ALARM  = 3'd4;
	localparam logic [2:0] TONE_CUSTOM = 3'd5;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] tone_type;
	} tone_req_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               sample_valid;
		logic               frame_end;
		logic               started;
		logic               finished;
		logic [2:0]         tone_id;
		logic               playing;
	} tone_rsp_t;

	typedef struct packed {
		logic               sample_valid;
		logic               frame_end;
		logic               started;
		logic               finished;
		logic [2:0]         tone_id;
		logic               playing;
		logic [SINE_AW-1:0] tone_idx;
		logic [SINE_AW-1:0] env_idx;
	} ctl_t;

	localparam logic [PHASE_W-1:0] TONE_INC [NUM_TONES] = '{
		PHASE_W'(((64'd880  << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE),
		PHASE_W'(((64'd440  << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE),
		PHASE_W'(((64'd220  << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE),
		PHASE_W'(((64'd660  << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE),
		PHASE_W'(((64'd1200 << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE),
		PHASE_W'(((64'd1000 << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE)
	};

	localparam logic [PHASE_W-1:0] ENV_INC =
		PHASE_W'(((64'd10 << PHASE_W) + SAMPLE_RATE / 2) / SAMPLE_RATE);

	localparam logic signed [15:0] TONE_AMP [NUM_TONES] = '{
		16'sd9830, 16'sd9830, 16'sd6554, 16'sd9830, 16'sd16384, 16'sd9830
	};

	typedef logic [14:0] qtab_t [QTR_DEPTH+1];

	function automatic longint mul_q30(input longint a, input longint unsigned b);
		longint unsigned m;
		longint unsigned p;
		m = (a < 0) ? longint'(-a) : longint'(a);
		p = (m * b) >> 30;
		return (a < 0) ? -longint'(p) : longint'(p);
	endfunction

	// sin over the quarter wave, odd polynomial in Q30, scaled to 32767
	function automatic logic [14:0] quarter_sine(input int j);
		longint unsigned u;
		longint unsigned u2;
		longint unsigned v;
		longint p;
		longint s;
		u  = longint'(j) << U_SHIFT;
		u2 = (u * u) >> 30;
		p  = 172272;
		p  = -5026994 + mul_q30(p, u2);
		p  = 85569306 + mul_q30(p, u2);
		p  = -693598700 + mul_q30(p, u2);
		p  = 1686629713 + mul_q30(p, u2);
		s  = mul_q30(p, u);
		if (s < 0)
			s = 0;
		v = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[14:0];
	endfunction

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int j = 0; j <= QTR_DEPTH; j++)
			t[j] = quarter_sine(j);
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// round half up of a*b/32768
	function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [31:0] p;
		p = 32'(a) * 32'(b) + 32'sd16384;
		return p[30:15];
	endfunction

endpackage

// File: hw/rtl/preset_tone_generator.sv
// Preset tone generator top level: DDS tone source, one result per transaction.
// Each result is registered through ctl_s1, the stage-2 registers and the output register.
// Throughput: one transaction per cycle; the three-stage pipeline stalls as a
// whole only while the output register holds an untaken result.
// Reset: asynchronous, clears pipeline valids and tone state; config regs
// return to 960 samples per frame and 48 frames per tone. Depends on ptg_pkg.
module preset_tone_generator import ptg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [SPF_W-1:0] cfg_data,
	input  logic             req_valid,
	output logic             req_ready,
	input  tone_req_t        req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output tone_rsp_t        rsp
);

	logic advance;
	logic accept;
	logic valid_s1;
	ctl_t ctl_s1;

	assign advance   = !rsp_valid || rsp_ready;
	assign req_ready = advance;
	assign accept    = req_valid && advance;

	ptg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.accept   (accept),
		.advance  (advance),
		.req      (req),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1)
	);

	ptg_shaper u_shaper (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// File: hw/rtl/ptg_sine_lookup.sv
// Sine lookup: folds a table index onto the quarter-wave table in ptg_pkg.
// Depends on ptg_pkg.
module ptg_sine_lookup import ptg_pkg::*; (
	input  logic [SINE_AW-1:0] idx,
	output logic signed [15:0] value
);

	logic [1:0]        quad;
	logic [QTR_AW-1:0] r;
	logic [QTR_AW:0]   j;
	logic [14:0]       mag;

	always_comb begin
		quad  = idx[SINE_AW-1 -: 2];
		r     = idx[QTR_AW-1:0];
		j     = quad[0] ? ((QTR_AW+1)'(QTR_DEPTH) - {1'b0, r}) : {1'b0, r};
		mag   = QTAB[j];
		value = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

// File: hw/rtl/ptg_ctrl.sv
// Tone control: configuration registers, phase accumulators, frame counters,
// and the first pipeline register carrying flags and table indexes.
// Depends on ptg_pkg.
module ptg_ctrl import ptg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [SPF_W-1:0] cfg_data,
	input  logic             accept,
	input  logic             advance,
	input  tone_req_t        req,
	output logic             valid_s1,
	output ctl_t             ctl_s1
);

	logic [SPF_W-1:0]   spf_q;
	logic [FPT_W-1:0]   fpt_q;
	logic [PHASE_W-1:0] tone_ph_q, tone_ph_d;
	logic [PHASE_W-1:0] env_ph_q, env_ph_d;
	logic [FPT_W-1:0]   frames_q, frames_d;
	logic [SIF_W-1:0]   sif_q, sif_d;
	logic [2:0]         sel_q, sel_d;
	logic [SPF_W-1:0]   spf_eff;
	logic [SPF_W-1:0]   sif_inc;
	logic [PHASE_W-1:0] env_use;
	ctl_t               ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spf_q <= SPF_RST;
			fpt_q <= FPT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_SPF: spf_q <= cfg_data;
				CFG_FPT: fpt_q <= cfg_data[FPT_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (spf_q == '0)
			spf_eff = SPF_W'(1);
		else if (spf_q > SPF_MAX)
			spf_eff = SPF_MAX;
		else
			spf_eff = spf_q;
	end

	always_comb begin
		tone_ph_d = tone_ph_q;
		env_ph_d  = env_ph_q;
		frames_d  = frames_q;
		sif_d     = sif_q;
		sel_d     = sel_q;
		env_use   = (sif_q == '0) ? '0 : env_ph_q;
		sif_inc   = {1'b0, sif_q} + SPF_W'(1);
		ctl       = '0;
		ctl.tone_idx = tone_ph_q[PHASE_W-1 -: SINE_AW];
		ctl.env_idx  = env_use[PHASE_W-1 -: SINE_AW];
		case (action_t'(req.action))
			ACT_TICK: begin
				if (frames_q != '0) begin
					ctl.sample_valid = 1'b1;
					tone_ph_d = tone_ph_q + TONE_INC[sel_q];
					env_ph_d  = env_use + ENV_INC;
					if (sif_inc >= spf_eff) begin
						ctl.frame_end = 1'b1;
						sif_d    = '0;
						frames_d = frames_q - FPT_W'(1);
					end else begin
						sif_d = sif_inc[SIF_W-1:0];
					end
				end
			end
			ACT_PLAY: begin
				sel_d       = (req.tone_type > TONE_CUSTOM) ? TONE_CUSTOM : req.tone_type;
				frames_d    = fpt_q;
				tone_ph_d   = '0;
				env_ph_d    = '0;
				sif_d       = '0;
				ctl.started = 1'b1;
			end
			ACT_STOP: begin
				ctl.finished = (frames_q != '0);
				frames_d     = '0;
				sif_d        = '0;
			end
			default: ;
		endcase
		ctl.tone_id = sel_d;
		ctl.playing = (frames_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_ph_q <= '0;
			env_ph_q  <= '0;
			frames_q  <= '0;
			sif_q     <= '0;
			sel_q     <= TONE_CUSTOM;
		end else if (accept) begin
			tone_ph_q <= tone_ph_d;
			env_ph_q  <= env_ph_d;
			frames_q  <= frames_d;
			sif_q     <= sif_d;
			sel_q     <= sel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (advance)
			ctl_s1 <= ctl;
	end

endmodule

// File: hw/rtl/ptg_shaper.sv
// Sample shaping: table lookups and alarm envelope (stage 2), amplitude
// scaling into the output register (stage 3). Depends on ptg_pkg, ptg_sine_lookup.
module ptg_shaper import ptg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  logic      valid_s1,
	input  ctl_t      ctl_s1,
	output logic      rsp_valid,
	output tone_rsp_t rsp
);

	logic signed [15:0] tone_s;
	logic signed [15:0] env_s;
	logic signed [15:0] env;
	logic signed [15:0] shaped;
	logic signed [15:0] s_s2;
	logic signed [15:0] amp_s2;
	ctl_t               ctl_s2;
	logic               valid_s2;
	tone_rsp_t          rsp_d;

	ptg_sine_lookup u_tone_lut (
		.idx   (ctl_s1.tone_idx),
		.value (tone_s)
	);

	ptg_sine_lookup u_env_lut (
		.idx   (ctl_s1.env_idx),
		.value (env_s)
	);

	always_comb begin
		env    = 16'((17'(env_s) + 17'sd32768) >>> 1);
		shaped = (ctl_s1.tone_id == TONE_ALARM) ? mul_q15(tone_s, env) : tone_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (advance) begin
			valid_s2  <= valid_s1;
			rsp_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2 <= ctl_s1;
			s_s2   <= shaped;
			amp_s2 <= TONE_AMP[ctl_s1.tone_id];
		end
	end

	always_comb begin
		rsp_d.sample       = ctl_s2.sample_valid ? mul_q15(s_s2, amp_s2) : '0;
		rsp_d.sample_valid = ctl_s2.sample_valid;
		rsp_d.frame_end    = ctl_s2.frame_end;
		rsp_d.started      = ctl_s2.started;
		rsp_d.finished     = ctl_s2.finished;
		rsp_d.tone_id      = ctl_s2.tone_id;
		rsp_d.playing      = ctl_s2.playing;
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp <= rsp_d;
	end

endmodule

// File: hw/rtl/ptg_checker.sv
// Port-level checker for preset_tone_generator, attached by bind.
// Depends on ptg_pkg.
module ptg_checker import ptg_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_we,
	input logic             cfg_idx,
	input logic [SPF_W-1:0] cfg_data,
	input logic             req_valid,
	input logic             req_ready,
	input tone_req_t        req,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input tone_rsp_t        rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while output stalled");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.sample_valid |-> rsp.sample == '0 && !rsp.frame_end)
		else $error("sample or frame end without a tone sample");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.sample_valid && (rsp.started || rsp.finished))
			&& !(rsp.finished && rsp.playing))
		else $error("inconsistent transaction flags");

endmodule

bind preset_tone_generator ptg_checker u_ptg_checker (.*);

// File: test/tb_preset_tone_generator.sv
// Self-checking testbench for preset_tone_generator: a directed table, then
// random play/tick/stop sequences under several frame settings, with random
// gaps and stalls in most phases. Depends on ptg_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_preset_tone_generator;
	import ptg_pkg::*;

	localparam int LATENCY      = 3;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 200;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 122;
	localparam int MAX_REPORTS  = 10;
	localparam longint unsigned RATE_HZ = 64'd48000;
	localparam int unsigned ENV_HZ      = 10;

	localparam logic [2:0] TONE_JOIN   = 3'd0;
	localparam logic [2:0] TONE_LEAVE  = 3'd1;
	localparam logic [2:0] TONE_MUTE   = 3'd2;
	localparam logic [2:0] TONE_UNMUTE = 3'd3;
	localparam logic [2:0] TONE_RSVD6  = 3'd6;
	localparam logic [2:0] TONE_RSVD7  = 3'd7;

	localparam int unsigned TONE_HZ [NUM_TONES] = '{880, 440, 220, 660, 1200, 1000};
	localparam int TONE_GAIN [NUM_TONES] = '{9830, 9830, 6554, 9830, 16384, 9830};

	localparam logic [SPF_W-1:0] SPF_PLAN [NUM_PHASES] =
		'{13'd5, 13'd1, 13'd0, 13'd8191, 13'd4096, 13'd2, 13'd7, 13'd3, 13'd16, 13'd4,
		  13'd1, 13'd6};
	localparam logic [SPF_W-1:0] FPT_PLAN [NUM_PHASES] =
		'{13'd3, 13'd1, 13'd2, 13'd255, 13'h1F00, 13'd255, 13'd2, 13'd5, 13'd1, 13'd4,
		  13'd3, 13'd6};

	typedef struct {
		action_t    act;
		logic [2:0] tone;
		bit         typed;
		tone_rsp_t  want;
	} dir_row_t;

	localparam int NUM_DIR = 25;

	dir_row_t dir_rows [NUM_DIR] = '{
		'{ACT_TICK, TONE_JOIN,   1'b1, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, TONE_CUSTOM, 1'b0}},
		'{ACT_STOP, TONE_JOIN,   1'b1, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, TONE_CUSTOM, 1'b0}},
		'{ACT_NOP,  TONE_RSVD7,  1'b1, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, TONE_CUSTOM, 1'b0}},
		'{ACT_PLAY, TONE_JOIN,   1'b1, '{16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, TONE_JOIN, 1'b1}},
		'{ACT_TICK, TONE_RSVD7,  1'b1, '{16'sd0, 1'b1, 1'b0, 1'b0, 1'b0, TONE_JOIN, 1'b1}},
		'{ACT_TICK, TONE_JOIN,   1'b0, '0},
		'{ACT_TICK, TONE_ALARM,  1'b0, '0},
		'{ACT_STOP, TONE_JOIN,   1'b1, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b1, TONE_JOIN, 1'b0}},
		'{ACT_STOP, TONE_JOIN,   1'b1, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, TONE_JOIN, 1'b0}},
		'{ACT_PLAY, TONE_RSVD6,  1'b1, '{16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, TONE_CUSTOM, 1'b1}},
		'{ACT_TICK, TONE_JOIN,   1'b0, '0},
		'{ACT_PLAY, TONE_RSVD7,  1'b1, '{16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, TONE_CUSTOM, 1'b1}},
		'{ACT_PLAY, TONE_LEAVE,  1'b1, '{16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, TONE_LEAVE, 1'b1}},
		'{ACT_TICK, TONE_JOIN,   1'b0, '0},
		'{ACT_PLAY, TONE_MUTE,   1'b0, '0},
		'{ACT_TICK, TONE_JOIN,   1'b0, '0},
		'{ACT_TICK, TONE_JOIN,   1'b0, '0},
		'{ACT_PLAY, TONE_UNMUTE, 1'b0, '0},
		'{ACT_TICK, TONE_JOIN,   1'b0, '0},
		'{ACT_PLAY, TONE_ALARM,  1'b1, '{16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, TONE_ALARM, 1'b1}},
		'{ACT_TICK, TONE_JOIN,   1'b1, '{16'sd0, 1'b1, 1'b0, 1'b0, 1'b0, TONE_ALARM, 1'b1}},
		'{ACT_TICK, TONE_JOIN,   1'b0, '0},
		'{ACT_TICK, TONE_JOIN,   1'b0, '0},
		'{ACT_NOP,  TONE_ALARM,  1'b1, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, TONE_ALARM, 1'b1}},
		'{ACT_STOP, TONE_CUSTOM, 1'b1, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b1, TONE_ALARM, 1'b0}}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_idx;
	logic [SPF_W-1:0] cfg_data;
	logic             req_valid;
	logic             req_ready;
	tone_req_t        req;
	logic             rsp_valid;
	logic             rsp_ready;
	tone_rsp_t        rsp;

	preset_tone_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// tone model state
	logic signed [15:0] sine_lut [1024];
	logic [31:0]        tone_acc;
	logic [31:0]        env_acc;
	logic [7:0]         frames_left;
	int                 frame_pos;
	logic [2:0]         cur_tone;
	logic [SPF_W-1:0]   spf_reg;
	logic [FPT_W-1:0]   fpt_reg;

	tone_rsp_t pending_rsp [$];
	int        mismatches;
	int        cycle_count;
	bit        gaps_on;
	bit        stalls_on;
	bit        hold_off_req;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint poly_scale(longint a, longint unsigned b);
		longint unsigned m;
		longint unsigned p;
		m = (a < 0) ? 64'(-a) : 64'(a);
		p = (m * b) >> 30;
		return (a < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic signed [15:0] sine_entry(int k);
		longint unsigned f;
		longint unsigned quad;
		longint unsigned r;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned v;
		longint p;
		longint s;
		logic signed [15:0] e;
		f = 64'(k);
		f = f << 22;
		quad = (f >> 30) & 64'd3;
		r = f & 64'h3FFF_FFFF;
		u = quad[0] ? (64'd1 << 30) - r : r;
		u2 = (u * u) >> 30;
		p = 172272;
		p = -5026994 + poly_scale(p, u2);
		p = 85569306 + poly_scale(p, u2);
		p = -693598700 + poly_scale(p, u2);
		p = 1686629713 + poly_scale(p, u2);
		s = poly_scale(p, u);
		if (s < 0)
			s = 0;
		v = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		e = 16'(v);
		return quad[1] ? -e : e;
	endfunction

	function automatic logic [31:0] step_of(int unsigned hz);
		longint unsigned n;
		n = 64'(hz);
		n = (n << 32) + RATE_HZ / 2;
		return 32'(n / RATE_HZ);
	endfunction

	// round half up of a*b/32768
	function automatic int gain_mul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b) + 64'sd16384;
		return int'(p >>> 15);
	endfunction

	function automatic tone_rsp_t tone_predict(action_t act, logic [2:0] tone);
		tone_rsp_t r;
		int spf;
		int s;
		int env;
		r = '0;
		case (act)
			ACT_TICK: begin
				if (frames_left != 0) begin
					if (spf_reg == 0)
						spf = 1;
					else if (spf_reg > SPF_MAX)
						spf = int'(SPF_MAX);
					else
						spf = int'(spf_reg);
					if (frame_pos == 0)
						env_acc = '0;
					s = sine_lut[tone_acc[31:22]];
					if (cur_tone == TONE_ALARM) begin
						env = (int'(sine_lut[env_acc[31:22]]) + 32768) >>> 1;
						s = gain_mul(s, env);
					end
					r.sample = 16'(gain_mul(s, TONE_GAIN[cur_tone]));
					r.sample_valid = 1'b1;
					tone_acc = tone_acc + step_of(TONE_HZ[cur_tone]);
					env_acc = env_acc + step_of(ENV_HZ);
					frame_pos++;
					if (frame_pos >= spf) begin
						r.frame_end = 1'b1;
						frame_pos = 0;
						frames_left = frames_left - 8'd1;
					end
				end
			end
			ACT_PLAY: begin
				cur_tone = (tone <= TONE_CUSTOM) ? tone : TONE_CUSTOM;
				frames_left = fpt_reg;
				tone_acc = '0;
				env_acc = '0;
				frame_pos = 0;
				r.started = 1'b1;
			end
			ACT_STOP: begin
				r.finished = (frames_left != 0);
				frames_left = '0;
				frame_pos = 0;
			end
			default: ;
		endcase
		r.tone_id = cur_tone;
		r.playing = (frames_left != 0);
		return r;
	endfunction

	task automatic flag_mismatch(string why, tone_rsp_t want, tone_rsp_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s at cycle %0d: exp sample=%0d v=%b fe=%b st=%b fin=%b id=%0d pl=%b",
				why, cycle_count, want.sample, want.sample_valid, want.frame_end,
				want.started, want.finished, want.tone_id, want.playing,
				"\n    got sample=%0d v=%b fe=%b st=%b fin=%b id=%0d pl=%b",
				got.sample, got.sample_valid, got.frame_end, got.started,
				got.finished, got.tone_id, got.playing);
	endtask

	always @(posedge clk) begin
		tone_rsp_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				flag_mismatch("unexpected transaction", '0, rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.sample !== want.sample || rsp.sample_valid !== want.sample_valid ||
						rsp.frame_end !== want.frame_end || rsp.started !== want.started ||
						rsp.finished !== want.finished || rsp.tone_id !== want.tone_id ||
						rsp.playing !== want.playing)
					flag_mismatch("mismatch", want, rsp);
			end
		end
	end

	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stalls_on && $urandom_range(0, 9) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(action_t act, logic [2:0] tone, bit typed, tone_rsp_t want);
		tone_rsp_t exp_rsp;
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req.action <= act;
		req.tone_type <= tone;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_ready !== 1'b1);
		exp_rsp = tone_predict(act, tone);
		pending_rsp.push_back(typed ? want : exp_rsp);
		@(negedge clk);
	endtask

	task automatic set_cfg(logic [SPF_W-1:0] spf, logic [SPF_W-1:0] fpt);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 1) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_SPF;
		cfg_data <= spf;
		@(negedge clk);
		spf_reg = spf;
		cfg_idx <= CFG_FPT;
		cfg_data <= fpt;
		@(negedge clk);
		fpt_reg = fpt[FPT_W-1:0];
		cfg_we <= 1'b0;
	endtask

	// mostly a play, a run of ticks and sometimes a stop; the rest is noise
	task automatic random_sequence(inout int count);
		int ticks;
		action_t act;
		if ($urandom_range(0, 99) < 75) begin
			send_item(ACT_PLAY, 3'($urandom_range(0, 7)), 1'b0, '0);
			count++;
			ticks = $urandom_range(1, 40);
			repeat (ticks) begin
				send_item(ACT_TICK, 3'($urandom), 1'b0, '0);
				count++;
			end
			if ($urandom_range(0, 1) == 1) begin
				send_item(ACT_STOP, 3'($urandom), 1'b0, '0);
				count++;
			end
		end else begin
			act = action_t'($urandom_range(0, 3));
			send_item(act, 3'($urandom), 1'b0, '0);
			if (act != ACT_NOP)
				count++;
		end
	endtask

	initial begin
		int count;
		for (int k = 0; k < 1024; k++)
			sine_lut[k] = sine_entry(k);
		mismatches = 0;
		cycle_count = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		hold_off_req = 1'b0;
		tone_acc = '0;
		env_acc = '0;
		frames_left = '0;
		frame_pos = 0;
		cur_tone = TONE_CUSTOM;
		spf_reg = SPF_RST;
		fpt_reg = FPT_RST;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_SPF;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].act, dir_rows[i].tone, dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p >= NUM_PHASES - 2) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			set_cfg(SPF_PLAN[p], FPT_PLAN[p]);
			if (p == NUM_PHASES - 3) begin
				gaps_on = 1'b0;
				hold_off_req = 1'b1;
			end
			count = 0;
			while (count < PHASE_ITEMS)
				random_sequence(count);
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/ptg_pkg.sv
hw/rtl/ptg_sine_lookup.sv
hw/rtl/ptg_ctrl.sv
hw/rtl/ptg_shaper.sv
hw/rtl/preset_tone_generator.sv
hw/rtl/ptg_checker.sv
test/tb_preset_tone_generator.sv
